// ===== hw/rtl/bpa_pkg.sv =====
// Shared types, constants and helpers for the bitmap page allocator.
// Used by the channel interfaces, the controller, the datapath and the top level.
`default_nettype none

package bpa_pkg;

   // Default configuration of the managed region.
   localparam int unsigned PAGE_COUNT_DEF  = 3840;
   localparam logic [31:0] REGION_BASE_DEF = 32'h0010_0000;
   localparam int unsigned PAGE_BYTES_DEF  = 4096;

   // Field widths of the request and response beats.
   localparam int unsigned OP_W     = 2;
   localparam int unsigned ADDR_W   = 32;
   localparam int unsigned PADDR_W  = 24;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned COUNT_W  = 12;

   // The usage map is stored as words of WORD_BITS pages each.
   localparam int unsigned WORD_BITS     = 32;
   localparam int unsigned BIT_AW        = 5;
   localparam int unsigned MAP_WORDS_DEF = (PAGE_COUNT_DEF + WORD_BITS - 1) / WORD_BITS;

   // Shared multiplier: a 32-bit operand times a 25-bit operand.
   localparam int unsigned MUL_A_W = 32;
   localparam int unsigned MUL_B_W = 25;
   localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE         = 2'd0,
      ST_OOM          = 2'd1,
      ST_OUTSIDE      = 2'd2,
      ST_ALREADY_FREE = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_CLEAR,
      S_SCAN_PRIME,
      S_SCAN,
      S_ALLOC_SET,
      S_FREE_RANGE,
      S_FREE_MUL,
      S_FREE_FIX,
      S_FREE_RD,
      S_FREE_UPD,
      S_RESP
   } state_type;

   typedef enum logic [1:0] {
      MUL_RECIP,
      MUL_BACK,
      MUL_PAGE
   } mul_sel_type;

   typedef enum logic [1:0] {
      WR_ZERO,
      WR_SET,
      WR_CLEAR
   } wr_mode_type;

   typedef struct packed {
      logic        req_ready;
      logic        req_capture;
      logic        addr_clr;
      logic        addr_inc;
      logic        chk_load;
      logic        rd_en;
      logic        rd_scan;
      logic        wr_en;
      wr_mode_type wr_mode;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        q_load;
      logic        idx_alloc;
      logic        idx_free;
      logic        cnt_inc;
      logic        cnt_dec;
      logic        cnt_clr;
      logic        rsp_load;
      status_type  rsp_status;
      logic        rsp_addr_en;
   } cmd_type;

   typedef struct packed {
      logic   req_valid;
      op_type req_op;
      logic   map_full;
      logic   outside;
      logic   word_has_free;
      logic   sweep_last;
      logic   page_used;
      logic   rsp_busy;
   } sts_type;

   // Position of the lowest set bit of a map word.
   function automatic logic [BIT_AW-1:0] lowest_set(input logic [WORD_BITS-1:0] bits);
      logic [BIT_AW-1:0] pos;
      pos = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (bits[i]) begin
            pos = BIT_AW'(i);
         end
      end
      return pos;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bpa_if.sv =====
// Valid/ready channel interfaces for request and response beats.
// Depends on bpa_pkg for the field widths.
`default_nettype none

interface bpa_req_if;
   logic                        valid;
   logic                        ready;
   logic [bpa_pkg::OP_W-1:0]    op;
   logic [bpa_pkg::ADDR_W-1:0]  address;

   modport source (output valid, op, address, input ready);
   modport sink   (input valid, op, address, output ready);
endinterface

interface bpa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bpa_pkg::PADDR_W-1:0]   page_address;
   logic [bpa_pkg::STATUS_W-1:0]  status;
   logic [bpa_pkg::COUNT_W-1:0]   used_count;
   logic [bpa_pkg::COUNT_W-1:0]   free_count;

   modport source (output valid, page_address, status, used_count, free_count, input ready);
   modport sink   (input valid, page_address, status, used_count, free_count, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bpa_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Depends on bpa_pkg for its default sizes.
`default_nettype none

module bpa_ram #(
   parameter int unsigned WIDTH = bpa_pkg::WORD_BITS,
   parameter int unsigned DEPTH = bpa_pkg::MAP_WORDS_DEF,
   localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/bpa_ctrl.sv =====
// Controller state machine of the bitmap page allocator.
// Depends on bpa_pkg; drives the datapath through cmd_type, reads sts_type.
`default_nettype none

module bpa_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire bpa_pkg::sts_type sts,
   output bpa_pkg::cmd_type      cmd
);

   bpa_pkg::state_type  state_ff, state_in;
   bpa_pkg::status_type pend_status_ff, pend_status_in;
   logic                pend_addr_ff, pend_addr_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= bpa_pkg::S_INIT;
         pend_status_ff <= bpa_pkg::ST_DONE;
         pend_addr_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         pend_status_ff <= pend_status_in;
         pend_addr_ff   <= pend_addr_in;
      end
   end

   // Next state and the status held for the response beat.
   always_comb begin
      state_in       = state_ff;
      pend_status_in = pend_status_ff;
      pend_addr_in   = pend_addr_ff;
      unique case (state_ff)
         bpa_pkg::S_INIT: begin
            if (sts.sweep_last) begin
               state_in = bpa_pkg::S_IDLE;
            end
         end
         bpa_pkg::S_IDLE: begin
            if (sts.req_valid) begin
               pend_status_in = bpa_pkg::ST_DONE;
               pend_addr_in   = 1'b0;
               unique case (sts.req_op)
                  bpa_pkg::OP_ALLOC: begin
                     if (sts.map_full) begin
                        pend_status_in = bpa_pkg::ST_OOM;
                        state_in       = bpa_pkg::S_RESP;
                     end else begin
                        state_in = bpa_pkg::S_SCAN_PRIME;
                     end
                  end
                  bpa_pkg::OP_FREE: begin
                     state_in = bpa_pkg::S_FREE_RANGE;
                  end
                  bpa_pkg::OP_CLEAR: begin
                     state_in = bpa_pkg::S_CLEAR;
                  end
                  default: begin
                     state_in = bpa_pkg::S_RESP;
                  end
               endcase
            end
         end
         bpa_pkg::S_CLEAR: begin
            if (sts.sweep_last) begin
               state_in = bpa_pkg::S_RESP;
            end
         end
         bpa_pkg::S_SCAN_PRIME: begin
            state_in = bpa_pkg::S_SCAN;
         end
         bpa_pkg::S_SCAN: begin
            if (sts.word_has_free) begin
               state_in = bpa_pkg::S_ALLOC_SET;
            end
         end
         bpa_pkg::S_ALLOC_SET: begin
            pend_addr_in = 1'b1;
            state_in     = bpa_pkg::S_RESP;
         end
         bpa_pkg::S_FREE_RANGE: begin
            if (sts.outside) begin
               pend_status_in = bpa_pkg::ST_OUTSIDE;
               state_in       = bpa_pkg::S_RESP;
            end else begin
               state_in = bpa_pkg::S_FREE_MUL;
            end
         end
         bpa_pkg::S_FREE_MUL: begin
            state_in = bpa_pkg::S_FREE_FIX;
         end
         bpa_pkg::S_FREE_FIX: begin
            state_in = bpa_pkg::S_FREE_RD;
         end
         bpa_pkg::S_FREE_RD: begin
            state_in = bpa_pkg::S_FREE_UPD;
         end
         bpa_pkg::S_FREE_UPD: begin
            if (!sts.page_used) begin
               pend_status_in = bpa_pkg::ST_ALREADY_FREE;
            end
            state_in = bpa_pkg::S_RESP;
         end
         bpa_pkg::S_RESP: begin
            if (!sts.rsp_busy) begin
               state_in = bpa_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = bpa_pkg::S_IDLE;
         end
      endcase
   end

   // Datapath commands.
   always_comb begin
      cmd             = '0;
      cmd.wr_mode     = bpa_pkg::WR_ZERO;
      cmd.mul_sel     = bpa_pkg::MUL_RECIP;
      cmd.rsp_status  = pend_status_ff;
      cmd.rsp_addr_en = pend_addr_ff;
      unique case (state_ff)
         bpa_pkg::S_INIT, bpa_pkg::S_CLEAR: begin
            cmd.wr_en    = 1'b1;
            cmd.wr_mode  = bpa_pkg::WR_ZERO;
            cmd.addr_inc = 1'b1;
            cmd.cnt_clr  = 1'b1;
         end
         bpa_pkg::S_IDLE: begin
            cmd.req_ready   = 1'b1;
            cmd.req_capture = sts.req_valid;
            cmd.addr_clr    = 1'b1;
         end
         bpa_pkg::S_SCAN_PRIME: begin
            cmd.rd_en    = 1'b1;
            cmd.rd_scan  = 1'b1;
            cmd.addr_inc = 1'b1;
            cmd.chk_load = 1'b1;
         end
         bpa_pkg::S_SCAN: begin
            // Keep the found word on the read port for the update that follows.
            if (sts.word_has_free) begin
               cmd.idx_alloc = 1'b1;
            end else begin
               cmd.rd_en    = 1'b1;
               cmd.rd_scan  = 1'b1;
               cmd.addr_inc = 1'b1;
               cmd.chk_load = 1'b1;
            end
         end
         bpa_pkg::S_ALLOC_SET: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_mode = bpa_pkg::WR_SET;
            cmd.cnt_inc = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = bpa_pkg::MUL_PAGE;
         end
         bpa_pkg::S_FREE_RANGE: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = bpa_pkg::MUL_RECIP;
         end
         bpa_pkg::S_FREE_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = bpa_pkg::MUL_BACK;
            cmd.q_load  = 1'b1;
         end
         bpa_pkg::S_FREE_FIX: begin
            cmd.idx_free = 1'b1;
         end
         bpa_pkg::S_FREE_RD: begin
            cmd.rd_en = 1'b1;
         end
         bpa_pkg::S_FREE_UPD: begin
            if (sts.page_used) begin
               cmd.wr_en   = 1'b1;
               cmd.wr_mode = bpa_pkg::WR_CLEAR;
               cmd.cnt_dec = 1'b1;
            end
         end
         bpa_pkg::S_RESP: begin
            cmd.rsp_load = !sts.rsp_busy;
         end
         default: begin
            cmd.req_ready = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== hw/rtl/bpa_dpath.sv =====
// Datapath of the bitmap page allocator: map RAM, scan and page index logic,
// shared multiplier, use counter and response register. Depends on bpa_pkg and bpa_ram.
`default_nettype none

module bpa_dpath #(
   parameter int unsigned PAGE_COUNT  = bpa_pkg::PAGE_COUNT_DEF,
   parameter logic [31:0] REGION_BASE = bpa_pkg::REGION_BASE_DEF,
   parameter int unsigned PAGE_BYTES  = bpa_pkg::PAGE_BYTES_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire bpa_pkg::cmd_type                cmd,
   output bpa_pkg::sts_type                     sts,
   input  wire logic                            req_valid,
   input  wire logic [bpa_pkg::OP_W-1:0]        req_op,
   input  wire logic [bpa_pkg::ADDR_W-1:0]      req_address,
   input  wire logic                            rsp_ready,
   output logic                                 rsp_valid,
   output logic      [bpa_pkg::PADDR_W-1:0]     rsp_page_address,
   output logic      [bpa_pkg::STATUS_W-1:0]    rsp_status,
   output logic      [bpa_pkg::COUNT_W-1:0]     rsp_used_count,
   output logic      [bpa_pkg::COUNT_W-1:0]     rsp_free_count
);

   localparam int unsigned WB        = bpa_pkg::WORD_BITS;
   localparam int unsigned BW        = bpa_pkg::BIT_AW;
   localparam int unsigned WORDS     = (PAGE_COUNT + WB - 1) / WB;
   localparam int unsigned AW        = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int unsigned IDX_W     = AW + BW;
   localparam int unsigned CNT_W     = $clog2(PAGE_COUNT + 1);
   localparam int unsigned LAST_BITS = PAGE_COUNT - (WORDS - 1) * WB;
   localparam logic [WB-1:0] LAST_MASK = WB'((64'd1 << LAST_BITS) - 64'd1);
   localparam logic [bpa_pkg::ADDR_W:0] SPAN =
      (bpa_pkg::ADDR_W + 1)'(64'(PAGE_COUNT) * 64'(PAGE_BYTES));
   // floor(2^32 / PAGE_BYTES): the quotient estimate is low by at most one.
   localparam logic [bpa_pkg::MUL_B_W-1:0] RECIP =
      bpa_pkg::MUL_B_W'((64'd1 << bpa_pkg::ADDR_W) / PAGE_BYTES);
   localparam logic [bpa_pkg::MUL_B_W-1:0] PB_B   = bpa_pkg::MUL_B_W'(PAGE_BYTES);
   localparam logic [bpa_pkg::ADDR_W-1:0]  PB_A   = bpa_pkg::ADDR_W'(PAGE_BYTES);
   localparam logic [bpa_pkg::PADDR_W-1:0] BASE_LOW = REGION_BASE[bpa_pkg::PADDR_W-1:0];

   logic [bpa_pkg::ADDR_W-1:0]  addr_ff, addr_in;
   logic [AW-1:0]               scan_ff, scan_in;
   logic [AW-1:0]               chk_ff, chk_in;
   logic [IDX_W-1:0]            q_ff, q_in;
   logic [IDX_W-1:0]            idx_ff, idx_in;
   logic [bpa_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic [CNT_W-1:0]            used_ff, used_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic [bpa_pkg::PADDR_W-1:0]        page_addr_ff, page_addr_in;
   logic [bpa_pkg::STATUS_W-1:0]       status_ff, status_in;
   logic [bpa_pkg::COUNT_W-1:0]        used_cnt_ff, used_cnt_in;
   logic [bpa_pkg::COUNT_W-1:0]        free_cnt_ff, free_cnt_in;

   logic [WB-1:0]              rd_data;
   logic [WB-1:0]              wr_data;
   logic [AW-1:0]              rd_addr;
   logic [AW-1:0]              wr_addr;
   logic [WB-1:0]              word_mask;
   logic [WB-1:0]              free_bits;
   logic [AW-1:0]              idx_word;
   logic [BW-1:0]              idx_bit;
   logic [WB-1:0]              bit_oh;
   logic [bpa_pkg::ADDR_W-1:0] offset;
   logic [bpa_pkg::ADDR_W-1:0] rem;
   logic [IDX_W-1:0]           q_fix;
   logic [bpa_pkg::MUL_A_W-1:0] mul_a;
   logic [bpa_pkg::MUL_B_W-1:0] mul_b;
   logic [bpa_pkg::PROD_W-1:0]  mul_p;
   logic [31:0]                 used_ext;
   logic [31:0]                 free_ext;

   bpa_ram #(
      .WIDTH (WB),
      .DEPTH (WORDS)
   ) u_map (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Page index split into map word and bit within the word.
   assign idx_word = idx_ff[IDX_W-1:BW];
   assign idx_bit  = idx_ff[BW-1:0];
   assign bit_oh   = WB'(1) << idx_bit;

   assign rd_addr = cmd.rd_scan ? scan_ff : idx_word;
   assign wr_addr = (cmd.wr_mode == bpa_pkg::WR_ZERO) ? scan_ff : idx_word;

   always_comb begin
      case (cmd.wr_mode)
         bpa_pkg::WR_SET:   wr_data = rd_data | bit_oh;
         bpa_pkg::WR_CLEAR: wr_data = rd_data & ~bit_oh;
         default:           wr_data = '0;
      endcase
   end

   // Padding bits past the last page never count as free.
   assign word_mask = (chk_ff == AW'(WORDS - 1)) ? LAST_MASK : '1;
   assign free_bits = ~rd_data & word_mask;

   // Range check on the captured free address, without wrap at the region end.
   assign offset = addr_ff - REGION_BASE;

   always_comb begin
      case (cmd.mul_sel)
         bpa_pkg::MUL_BACK: begin
            mul_a = bpa_pkg::MUL_A_W'(prod_ff[bpa_pkg::ADDR_W +: IDX_W]);
            mul_b = PB_B;
         end
         bpa_pkg::MUL_PAGE: begin
            mul_a = bpa_pkg::MUL_A_W'(idx_ff);
            mul_b = PB_B;
         end
         default: begin
            mul_a = offset;
            mul_b = RECIP;
         end
      endcase
   end

   assign mul_p = bpa_pkg::PROD_W'(mul_a) * bpa_pkg::PROD_W'(mul_b);

   // prod_ff holds q * PAGE_BYTES here; one correction step finishes the division.
   assign rem   = offset - prod_ff[bpa_pkg::ADDR_W-1:0];
   assign q_fix = q_ff + IDX_W'(rem >= PB_A);

   assign used_ext = 32'(used_ff);
   assign free_ext = 32'(PAGE_COUNT) - used_ext;

   always_comb begin
      addr_in = cmd.req_capture ? req_address : addr_ff;

      if (cmd.addr_clr) begin
         scan_in = '0;
      end else if (cmd.addr_inc) begin
         scan_in = scan_ff + AW'(1);
      end else begin
         scan_in = scan_ff;
      end

      chk_in  = cmd.chk_load ? scan_ff : chk_ff;
      q_in    = cmd.q_load ? prod_ff[bpa_pkg::ADDR_W +: IDX_W] : q_ff;
      prod_in = cmd.mul_en ? mul_p : prod_ff;

      if (cmd.idx_alloc) begin
         idx_in = {chk_ff, bpa_pkg::lowest_set(free_bits)};
      end else if (cmd.idx_free) begin
         idx_in = q_fix;
      end else begin
         idx_in = idx_ff;
      end

      if (cmd.cnt_clr) begin
         used_in = '0;
      end else if (cmd.cnt_inc) begin
         used_in = used_ff + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
         used_in = used_ff - CNT_W'(1);
      end else begin
         used_in = used_ff;
      end

      rsp_valid_in = cmd.rsp_load | (rsp_valid_ff & ~rsp_ready);
      page_addr_in = page_addr_ff;
      status_in    = status_ff;
      used_cnt_in  = used_cnt_ff;
      free_cnt_in  = free_cnt_ff;
      if (cmd.rsp_load) begin
         page_addr_in = cmd.rsp_addr_en ? prod_ff[bpa_pkg::PADDR_W-1:0] + BASE_LOW : '0;
         status_in    = cmd.rsp_status;
         used_cnt_in  = used_ext[bpa_pkg::COUNT_W-1:0];
         free_cnt_in  = free_ext[bpa_pkg::COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff      <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         scan_ff      <= scan_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff      <= addr_in;
      chk_ff       <= chk_in;
      q_ff         <= q_in;
      idx_ff       <= idx_in;
      prod_ff      <= prod_in;
      page_addr_ff <= page_addr_in;
      status_ff    <= status_in;
      used_cnt_ff  <= used_cnt_in;
      free_cnt_ff  <= free_cnt_in;
   end

   always_comb begin
      sts.req_valid     = req_valid;
      sts.req_op        = bpa_pkg::op_type'(req_op);
      sts.map_full      = (used_ff == CNT_W'(PAGE_COUNT));
      sts.outside       = (addr_ff < REGION_BASE) || ({1'b0, offset} >= SPAN);
      sts.word_has_free = |free_bits;
      sts.sweep_last    = (scan_ff == AW'(WORDS - 1));
      sts.page_used     = rd_data[idx_bit];
      sts.rsp_busy      = rsp_valid_ff & ~rsp_ready;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_page_address = page_addr_ff;
   assign rsp_status       = status_ff;
   assign rsp_used_count   = used_cnt_ff;
   assign rsp_free_count   = free_cnt_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/bitmap_page_allocator_top.sv =====
// Bitmap page allocator. W = ceil(PAGE_COUNT / 32) map words (120 by default).
// Allocate: the worst case from request beat to response beat is set by the
// word-per-cycle scan through the one read port of the map RAM; out of memory skips the scan.
// Free: range check with reciprocal multiply, back multiply, correction, read, update.
// Clear: a pass over the W map words. One request is worked on at a time.
// After reset a clearing pass zeroes the map; the request side stays not ready.
`default_nettype none

module bitmap_page_allocator_top #(
   parameter int unsigned PAGE_COUNT  = bpa_pkg::PAGE_COUNT_DEF,
   parameter logic [31:0] REGION_BASE = bpa_pkg::REGION_BASE_DEF,
   parameter int unsigned PAGE_BYTES  = bpa_pkg::PAGE_BYTES_DEF
) (
   input wire logic   clock,
   input wire logic   reset,
   bpa_req_if.sink    req_ch,
   bpa_rsp_if.source  rsp_ch
);

   bpa_pkg::cmd_type cmd;
   bpa_pkg::sts_type sts;

   bpa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   bpa_dpath #(
      .PAGE_COUNT  (PAGE_COUNT),
      .REGION_BASE (REGION_BASE),
      .PAGE_BYTES  (PAGE_BYTES)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_valid        (req_ch.valid),
      .req_op           (req_ch.op),
      .req_address      (req_ch.address),
      .rsp_ready        (rsp_ch.ready),
      .rsp_valid        (rsp_ch.valid),
      .rsp_page_address (rsp_ch.page_address),
      .rsp_status       (rsp_ch.status),
      .rsp_used_count   (rsp_ch.used_count),
      .rsp_free_count   (rsp_ch.free_count)
   );

   assign req_ch.ready = cmd.req_ready;

   // A finished result never overwrites a beat that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !sts.rsp_busy)
      else $error("response register loaded while a beat is pending");

   // The use count never grows past the number of pages.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cmd.cnt_inc |-> !sts.map_full)
      else $error("page allocated with the map full");

   // Out of memory is only reported when no page is free.
   a_oom_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status == bpa_pkg::ST_OOM) |-> (rsp_ch.free_count == '0))
      else $error("out of memory reported with free pages left");

   // A failed request never carries a page address.
   a_addr_on_fail: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status != bpa_pkg::ST_DONE) |-> (rsp_ch.page_address == '0))
      else $error("page address returned on a failed request");

endmodule

`default_nettype wire

// ===== verif/bitmap_page_allocator_top_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for bitmap_page_allocator_top: directed table, random traffic
// and a long response stall. Depends on bpa_pkg and the bpa_req_if and bpa_rsp_if
// channel interfaces.

module bitmap_page_allocator_top_test;

   import bpa_pkg::*;

   localparam int unsigned PAGE_COUNT   = PAGE_COUNT_DEF;
   localparam logic [31:0] REGION_BASE  = REGION_BASE_DEF;
   localparam int unsigned PAGE_BYTES   = PAGE_BYTES_DEF;
   localparam logic [63:0] REGION_SPAN  = 64'(PAGE_COUNT) * 64'(PAGE_BYTES);
   localparam logic [31:0] REGION_END   = 32'(64'(REGION_BASE) + REGION_SPAN);
   localparam int          RANDOM_ITEMS = 930;
   localparam int          LONG_HOLD    = 3000;
   localparam int          SETTLE       = 150;

   typedef struct packed {
      logic [PADDR_W-1:0] page_address;
      status_type         status;
      logic [COUNT_W-1:0] used_count;
      logic [COUNT_W-1:0] free_count;
   } alloc_result_type;

   typedef struct packed {
      op_type           op;
      logic [31:0]      address;
      logic             typed;
      alloc_result_type result;
   } directed_row_type;

   // Rows with typed = 0 are checked against the predictor only.
   localparam directed_row_type DIRECTED_ROWS [20] = '{
      '{OP_ALLOC, 32'hFFFF_FFFF, 1'b1, '{24'h10_0000, ST_DONE,         12'd1, 12'd3839}},
      '{OP_ALLOC, 32'h0000_0000, 1'b1, '{24'h10_1000, ST_DONE,         12'd2, 12'd3838}},
      '{OP_FREE,  32'h0000_0000, 1'b1, '{24'h00_0000, ST_OUTSIDE,      12'd2, 12'd3838}},
      '{OP_FREE,  32'hFFFF_FFFF, 1'b1, '{24'h00_0000, ST_OUTSIDE,      12'd2, 12'd3838}},
      '{OP_FREE,  32'h000F_FFFF, 1'b1, '{24'h00_0000, ST_OUTSIDE,      12'd2, 12'd3838}},
      '{OP_FREE,  32'h0100_0000, 1'b1, '{24'h00_0000, ST_OUTSIDE,      12'd2, 12'd3838}},
      '{OP_FREE,  32'h00FF_FFFF, 1'b1, '{24'h00_0000, ST_ALREADY_FREE, 12'd2, 12'd3838}},
      '{OP_FREE,  32'h0010_0FFF, 1'b1, '{24'h00_0000, ST_DONE,         12'd1, 12'd3839}},
      '{OP_FREE,  32'h0010_0000, 1'b1, '{24'h00_0000, ST_ALREADY_FREE, 12'd1, 12'd3839}},
      '{OP_ALLOC, 32'h0000_0000, 1'b1, '{24'h10_0000, ST_DONE,         12'd2, 12'd3838}},
      '{OP_NONE,  32'hA5A5_A5A5, 1'b1, '{24'h00_0000, ST_DONE,         12'd2, 12'd3838}},
      '{OP_ALLOC, 32'h5A5A_5A5A, 1'b1, '{24'h10_2000, ST_DONE,         12'd3, 12'd3837}},
      '{OP_FREE,  32'h0010_1800, 1'b0, '{24'h00_0000, ST_DONE,         12'd0, 12'd0}},
      '{OP_ALLOC, 32'h0000_0000, 1'b0, '{24'h00_0000, ST_DONE,         12'd0, 12'd0}},
      '{OP_CLEAR, 32'h5A5A_5A5A, 1'b1, '{24'h00_0000, ST_DONE,         12'd0, 12'd3840}},
      '{OP_FREE,  32'h0010_2000, 1'b1, '{24'h00_0000, ST_ALREADY_FREE, 12'd0, 12'd3840}},
      '{OP_ALLOC, 32'h0000_0000, 1'b1, '{24'h10_0000, ST_DONE,         12'd1, 12'd3839}},
      '{OP_CLEAR, 32'hFFFF_FFFF, 1'b1, '{24'h00_0000, ST_DONE,         12'd0, 12'd3840}},
      '{OP_NONE,  32'h0000_0000, 1'b1, '{24'h00_0000, ST_DONE,         12'd0, 12'd3840}},
      '{OP_CLEAR, 32'h0000_0000, 1'b1, '{24'h00_0000, ST_DONE,         12'd0, 12'd3840}}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   bpa_req_if req_ch ();
   bpa_rsp_if rsp_ch ();

   bitmap_page_allocator_top #(
      .PAGE_COUNT  (PAGE_COUNT),
      .REGION_BASE (REGION_BASE),
      .PAGE_BYTES  (PAGE_BYTES)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #5 clock = ~clock;

   // Shadow of the usage map and page count, advanced on every accepted request beat.
   bit               page_used [PAGE_COUNT];
   int unsigned      shadow_used_count = 0;
   alloc_result_type awaited_results [$];
   int               failures = 0;
   bit               no_idle = 1'b0;
   bit               rsp_hold_request = 1'b0;

   function automatic alloc_result_type allocator_step(input op_type op,
                                                       input logic [31:0] addr);
      alloc_result_type r;
      logic [63:0]      offset;
      logic [63:0]      base_addr;
      int               found;
      r = '0;
      r.status = ST_DONE;
      case (op)
         OP_ALLOC: begin
            found = -1;
            for (int i = 0; i < PAGE_COUNT; i++) begin
               if (!page_used[i]) begin
                  found = i;
                  break;
               end
            end
            if (found < 0) begin
               r.status = ST_OOM;
            end else begin
               page_used[found] = 1'b1;
               shadow_used_count++;
               base_addr = 64'(REGION_BASE) + 64'(found) * 64'(PAGE_BYTES);
               r.page_address = base_addr[PADDR_W-1:0];
            end
         end
         OP_FREE: begin
            offset = 64'(addr) - 64'(REGION_BASE);
            if (addr < REGION_BASE || offset >= REGION_SPAN) begin
               r.status = ST_OUTSIDE;
            end else if (!page_used[int'(offset / PAGE_BYTES)]) begin
               r.status = ST_ALREADY_FREE;
            end else begin
               page_used[int'(offset / PAGE_BYTES)] = 1'b0;
               if (shadow_used_count > 0) shadow_used_count--;
            end
         end
         OP_CLEAR: begin
            foreach (page_used[i]) page_used[i] = 1'b0;
            shadow_used_count = 0;
         end
         default: begin
         end
      endcase
      r.used_count = COUNT_W'(shadow_used_count);
      r.free_count = COUNT_W'(PAGE_COUNT - shadow_used_count);
      return r;
   endfunction

   // Mostly an address inside a page in use, otherwise stray and boundary addresses.
   function automatic logic [31:0] choose_release_address();
      int          sel;
      int          idx;
      int          start;
      logic [63:0] a;
      sel = $urandom_range(0, 99);
      if (sel < 60 && shadow_used_count != 0) begin
         start = $urandom_range(0, PAGE_COUNT - 1);
         idx = start;
         for (int k = 0; k < PAGE_COUNT; k++) begin
            idx = (start + k) % PAGE_COUNT;
            if (page_used[idx]) break;
         end
         a = 64'(REGION_BASE) + 64'(idx) * 64'(PAGE_BYTES) + 64'($urandom_range(0, PAGE_BYTES - 1));
         return a[31:0];
      end else if (sel < 75) begin
         return REGION_BASE + $urandom_range(0, 32'(REGION_SPAN) - 1);
      end else if (sel < 90) begin
         return $urandom;
      end
      case ($urandom_range(0, 5))
         0:       return 32'h0000_0000;
         1:       return REGION_BASE - 1;
         2:       return REGION_BASE;
         3:       return REGION_END - 1;
         4:       return REGION_END;
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   // Offers one request beat after a random gap and records its expected result on acceptance.
   task automatic issue_request(input op_type op, input logic [31:0] addr, input logic typed,
                                input alloc_result_type typed_result);
      int               gap;
      alloc_result_type predicted;
      gap = no_idle ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.op      <= op;
      req_ch.address <= addr;
      do @(posedge clock); while (!req_ch.ready);
      predicted = allocator_step(op, addr);
      awaited_results.push_back(typed ? typed_result : predicted);
   endtask

   // Withdraws the request side so no beat is offered while draining.
   task automatic wait_for_results();
      req_ch.valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
   endtask

   initial begin
      int          sel;
      op_type      op;
      logic [31:0] addr;
      req_ch.valid   <= 1'b0;
      req_ch.op      <= OP_ALLOC;
      req_ch.address <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < $size(DIRECTED_ROWS); r++) begin
         issue_request(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].address, DIRECTED_ROWS[r].typed,
                       DIRECTED_ROWS[r].result);
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 120 == 119) wait_for_results();
         if (n == 300) rsp_hold_request = 1'b1;
         no_idle = (n >= 600 && n < 680);
         sel = $urandom_range(0, 99);
         if (sel < 48) op = OP_ALLOC;
         else if (sel < 93) op = OP_FREE;
         else if (sel < 97) op = OP_NONE;
         else op = OP_CLEAR;
         addr = (op == OP_FREE) ? choose_release_address() : $urandom;
         issue_request(op, addr, 1'b0, '0);
      end

      wait_for_results();
      repeat (SETTLE) @(posedge clock);
      if (failures == 0) begin
         $display("bitmap_page_allocator_top verification clean");
      end else begin
         $display("bitmap_page_allocator_top verification failed");
      end
      $finish;
   end

   // Response side: random stall per beat, and one long hold that backs up the request side.
   initial begin
      int stall;
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 15);
         if (rsp_hold_request) begin
            stall = LONG_HOLD;
            rsp_hold_request = 1'b0;
         end
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   always @(posedge clock) begin
      alloc_result_type exp_result;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (awaited_results.size() == 0) begin
            $error("response beat with no request outstanding");
            failures++;
         end else begin
            exp_result = awaited_results.pop_front();
            if (rsp_ch.page_address !== exp_result.page_address) begin
               $error("page_address: expected %h, got %h", exp_result.page_address,
                      rsp_ch.page_address);
               failures++;
            end
            if (rsp_ch.status !== exp_result.status) begin
               $error("status: expected %0d, got %0d", exp_result.status, rsp_ch.status);
               failures++;
            end
            if (rsp_ch.used_count !== exp_result.used_count) begin
               $error("used_count: expected %0d, got %0d", exp_result.used_count,
                      rsp_ch.used_count);
               failures++;
            end
            if (rsp_ch.free_count !== exp_result.free_count) begin
               $error("free_count: expected %0d, got %0d", exp_result.free_count,
                      rsp_ch.free_count);
               failures++;
            end
         end
      end
   end

   initial begin
      #40_000_000;
      $display("bitmap_page_allocator_top verification failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/bpa_pkg.sv
hw/rtl/bpa_if.sv
hw/rtl/bpa_ram.sv
hw/rtl/bpa_ctrl.sv
hw/rtl/bpa_dpath.sv
hw/rtl/bitmap_page_allocator_top.sv
verif/bitmap_page_allocator_top_test.sv
